### rtl/core/fbf_pkg.sv
// Shared types, codes and helpers for the tiled frame buffer fill block.
// No dependencies; every other file of the block refers to this package.
package fbf_pkg;

  // Default geometry limits, handed to the top level as parameter defaults
  localparam int TILE_PIXELS_DEF   = 32;
  localparam int MAX_DIMENSION_DEF = 2048;

  // Fixed field widths
  localparam int REG_W       = 12;
  localparam int WORD_W      = 32;
  localparam int IDX_W       = 22;
  localparam int CFG_INDEX_W = 3;

  // Reset value of both buffer dimensions
  localparam int BUFFER_RESET = 32;

  // Chequer pattern: grey level and the counter bit that selects the square
  localparam logic [7:0] CHECK_GREY = 8'hb0;
  localparam int         CHECK_BIT  = 3;

  typedef enum logic [1:0] {
    FILL_IMAGE   = 2'd0,
    FILL_CHECKER = 2'd1,
    FILL_SOLID   = 2'd2
  } fill_mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FILL_MODE     = 3'd0,
    REG_BUFFER_WIDTH  = 3'd1,
    REG_BUFFER_HEIGHT = 3'd2,
    REG_SRC_WIDTH     = 3'd3,
    REG_SRC_HEIGHT    = 3'd4,
    REG_SOLID_COLOR   = 3'd5
  } cfg_reg_t;

  // Registers whose width does not follow from the geometry parameters
  typedef struct packed {
    fill_mode_t          fill_mode;
    logic [REG_W-1:0]    src_width;
    logic [REG_W-1:0]    src_height;
    logic [WORD_W-1:0]   solid_color;
  } cfg_t;

  // colour * alpha / 255, truncated; exact for every 8-bit pair
  function automatic logic [7:0] premul(input logic [7:0] c, input logic [7:0] a);
    logic [15:0] p;
    logic [16:0] s;
    begin
      p = c * a;
      s = 17'(p) + 17'(p[15:8]) + 17'd1;
      premul = s[15:8];
    end
  endfunction

endpackage

### rtl/core/fbf_if.sv
// Channel interfaces of the tiled frame buffer fill block: pixels in,
// pixel writes out, configuration writes. Depends on fbf_pkg.
interface fbf_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [fbf_pkg::WORD_W-1:0] source_pixel;

  modport source (output valid, output source_pixel, input ready);
  modport sink   (input valid, input source_pixel, output ready);
endinterface

interface fbf_write_if;
  logic                      valid;
  logic                      ready;
  logic [fbf_pkg::IDX_W-1:0]  pixel_index;
  logic [fbf_pkg::WORD_W-1:0] pixel_word;
  logic                      frame_last;

  modport source (output valid, output pixel_index, output pixel_word,
                  output frame_last, input ready);
  modport sink   (input valid, input pixel_index, input pixel_word,
                  input frame_last, output ready);
endinterface

interface fbf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fbf_pkg::CFG_INDEX_W-1:0] index;
  logic [fbf_pkg::WORD_W-1:0]      value;

  modport source (output valid, output index, output value, input ready);
  modport sink   (input valid, input index, input value, output ready);
endinterface

### rtl/core/fbf_cfg.sv
// Configuration registers, with buffer sizes clamped and rounded up to whole
// tiles. Depends on fbf_pkg and fbf_cfg_if.
module fbf_cfg #(
  parameter int TILE_PIXELS   = fbf_pkg::TILE_PIXELS_DEF,
  parameter int MAX_DIMENSION = fbf_pkg::MAX_DIMENSION_DEF,
  localparam int DIM_W     = $clog2(MAX_DIMENSION + 1),
  localparam int TILES_MAX = (MAX_DIMENSION + TILE_PIXELS - 1) / TILE_PIXELS,
  localparam int PAD_MAX   = TILES_MAX * TILE_PIXELS,
  localparam int PW_W      = $clog2(PAD_MAX + 1)
) (
  input  logic              clk,
  input  logic              rst,
  fbf_cfg_if.sink           cfg,
  output fbf_pkg::cfg_t     regs,
  output logic [DIM_W-1:0]  buf_w,
  output logic [DIM_W-1:0]  buf_h,
  output logic [PW_W-1:0]   pad_w,
  output logic [PW_W-1:0]   pad_h
);

  localparam int CMP_W  = ((DIM_W > fbf_pkg::REG_W) ? DIM_W : fbf_pkg::REG_W) + 1;
  localparam int XW     = $clog2(MAX_DIMENSION + TILE_PIXELS);
  localparam int SHIFT  = XW + $clog2(TILE_PIXELS);
  localparam int MW     = SHIFT + 1;
  localparam longint RECIP = ((longint'(1) << SHIFT) + TILE_PIXELS - 1) / TILE_PIXELS;
  localparam int QW     = $clog2(TILES_MAX + 1);
  localparam int DIM_RST   = (fbf_pkg::BUFFER_RESET > MAX_DIMENSION) ?
                             MAX_DIMENSION : fbf_pkg::BUFFER_RESET;
  localparam int TILES_RST = (DIM_RST + TILE_PIXELS - 1) / TILE_PIXELS;
  localparam int PAD_RST   = TILES_RST * TILE_PIXELS;

  logic [CMP_W-1:0]    wr_raw;
  logic [DIM_W-1:0]    wr_dim;
  logic [XW-1:0]       wr_x;
  logic [XW+MW-1:0]    wr_prod;
  logic [QW-1:0]       wr_tiles;
  logic [QW-1:0]       tiles_w;
  logic [QW-1:0]       tiles_h;
  fbf_pkg::cfg_reg_t   wr_reg;

  assign cfg.ready = 1'b1;
  assign wr_reg    = fbf_pkg::cfg_reg_t'(cfg.index);

  // Clamp into 1..MAX_DIMENSION, then count tiles by reciprocal multiply
  always_comb begin
    wr_raw = CMP_W'(cfg.value[fbf_pkg::REG_W-1:0]);
    if (wr_raw == '0) begin
      wr_dim = DIM_W'(1);
    end else if (wr_raw > CMP_W'(MAX_DIMENSION)) begin
      wr_dim = DIM_W'(MAX_DIMENSION);
    end else begin
      wr_dim = DIM_W'(wr_raw);
    end
    wr_x     = XW'(wr_dim) + XW'(TILE_PIXELS - 1);
    wr_prod  = (XW+MW)'(wr_x) * (XW+MW)'(RECIP);
    wr_tiles = QW'(wr_prod >> SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.fill_mode   <= fbf_pkg::FILL_IMAGE;
      regs.src_width   <= '0;
      regs.src_height  <= '0;
      regs.solid_color <= '0;
      buf_w   <= DIM_W'(DIM_RST);
      buf_h   <= DIM_W'(DIM_RST);
      tiles_w <= QW'(TILES_RST);
      tiles_h <= QW'(TILES_RST);
      pad_w   <= PW_W'(PAD_RST);
      pad_h   <= PW_W'(PAD_RST);
    end else begin
      pad_w <= PW_W'(tiles_w * TILE_PIXELS);
      pad_h <= PW_W'(tiles_h * TILE_PIXELS);
      if (cfg.valid) begin
        case (wr_reg)
          fbf_pkg::REG_FILL_MODE: begin
            regs.fill_mode <= fbf_pkg::fill_mode_t'(cfg.value[1:0]);
          end
          fbf_pkg::REG_BUFFER_WIDTH: begin
            buf_w   <= wr_dim;
            tiles_w <= wr_tiles;
          end
          fbf_pkg::REG_BUFFER_HEIGHT: begin
            buf_h   <= wr_dim;
            tiles_h <= wr_tiles;
          end
          fbf_pkg::REG_SRC_WIDTH: begin
            regs.src_width <= cfg.value[fbf_pkg::REG_W-1:0];
          end
          fbf_pkg::REG_SRC_HEIGHT: begin
            regs.src_height <= cfg.value[fbf_pkg::REG_W-1:0];
          end
          fbf_pkg::REG_SOLID_COLOR: begin
            regs.solid_color <= cfg.value;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

### rtl/core/fbf_pixel.sv
// Pixel word selection: premultiplied image, chequer pattern or solid colour.
// Purely combinational. Depends on fbf_pkg.
module fbf_pixel #(
  parameter int TILE_PIXELS   = fbf_pkg::TILE_PIXELS_DEF,
  parameter int MAX_DIMENSION = fbf_pkg::MAX_DIMENSION_DEF,
  localparam int DIM_W     = $clog2(MAX_DIMENSION + 1),
  localparam int TILES_MAX = (MAX_DIMENSION + TILE_PIXELS - 1) / TILE_PIXELS,
  localparam int PAD_MAX   = TILES_MAX * TILE_PIXELS,
  localparam int PW_W      = $clog2(PAD_MAX + 1),
  localparam int CW        = $clog2(PAD_MAX)
) (
  input  logic [CW-1:0]               col,
  input  logic [CW-1:0]               row,
  input  fbf_pkg::cfg_t               regs,
  input  logic [DIM_W-1:0]            buf_w,
  input  logic [DIM_W-1:0]            buf_h,
  input  logic [fbf_pkg::WORD_W-1:0]  source_pixel,
  output logic [fbf_pkg::WORD_W-1:0]  word
);

  localparam int CMP_W = ((PW_W > fbf_pkg::REG_W) ? PW_W : fbf_pkg::REG_W) + 1;

  logic [CMP_W-1:0] col_x;
  logic [CMP_W-1:0] row_x;
  logic             in_buffer;
  logic             in_image;
  logic [7:0]       alpha;

  assign col_x     = CMP_W'(col);
  assign row_x     = CMP_W'(row);
  assign in_buffer = (col_x < CMP_W'(buf_w)) && (row_x < CMP_W'(buf_h));
  assign in_image  = (col_x < CMP_W'(regs.src_width)) &&
                     (row_x < CMP_W'(regs.src_height));
  assign alpha     = source_pixel[31:24];

  always_comb begin
    word = '0;
    case (regs.fill_mode)
      fbf_pkg::FILL_IMAGE: begin
        if (in_image) begin
          word = {alpha,
                  fbf_pkg::premul(source_pixel[23:16], alpha),
                  fbf_pkg::premul(source_pixel[15:8], alpha),
                  fbf_pkg::premul(source_pixel[7:0], alpha)};
        end
      end
      fbf_pkg::FILL_CHECKER: begin
        word = in_buffer ? '1 : '0;
        // grey on squares of matching parity, padding included
        if (col[fbf_pkg::CHECK_BIT] == row[fbf_pkg::CHECK_BIT]) begin
          word = {word[31:24], fbf_pkg::CHECK_GREY, fbf_pkg::CHECK_GREY,
                  fbf_pkg::CHECK_GREY};
        end
      end
      fbf_pkg::FILL_SOLID: begin
        if (in_buffer) begin
          word = regs.solid_color;
        end
      end
      default: begin
        word = '0;
      end
    endcase
  end

endmodule

### rtl/core/tiled_frame_buffer_fill.sv
// Tiled frame buffer fill: top level with the raster walk and pixel pipeline.
// Depends on fbf_pkg, the channel interfaces, fbf_cfg and fbf_pixel.
//
// Walks a frame buffer padded to whole tiles in raster order and emits one
// pixel write per transfer on pixels: the linear index (row times padded
// width plus column, low 22 bits), the RGBA word and a flag on the last pixel
// of the padded frame. Throughput is one pixel per clock while writes is
// ready; each pixel passes an input register and then a result register
// before its write is presented, and a stalled writes channel holds one
// pixel in each register before pixels is throttled. The path between the
// two registers holds the row times padded width multiply and three 8x8
// alpha multiplies.
// A buffer size write is clamped to 1..MAX_DIMENSION and turned into a tile
// count in its own cycle; the padded size follows in the next cycle, in time
// for a pixel transferred right after the write. Config writes leave the walk
// counters alone: a column beyond a shrunken padded width wraps on the next
// pixel, a row beyond the padded height at its row's end. Write registers
// only while no pixel is in flight. No clearing pass is needed after reset.
module tiled_frame_buffer_fill #(
  parameter int TILE_PIXELS   = fbf_pkg::TILE_PIXELS_DEF,
  parameter int MAX_DIMENSION = fbf_pkg::MAX_DIMENSION_DEF
) (
  input  logic          clk,
  input  logic          rst,
  fbf_cfg_if.sink       cfg,
  fbf_pixel_if.sink     pixels,
  fbf_write_if.source   writes
);

  localparam int DIM_W     = $clog2(MAX_DIMENSION + 1);
  localparam int TILES_MAX = (MAX_DIMENSION + TILE_PIXELS - 1) / TILE_PIXELS;
  localparam int PAD_MAX   = TILES_MAX * TILE_PIXELS;
  localparam int PW_W      = $clog2(PAD_MAX + 1);
  localparam int CW        = $clog2(PAD_MAX);
  localparam int LIM_W     = PW_W + 1;
  localparam int PROD_W    = CW + PW_W;

  fbf_pkg::cfg_t                regs;
  logic [DIM_W-1:0]             buf_w;
  logic [DIM_W-1:0]             buf_h;
  logic [PW_W-1:0]              pad_w;
  logic [PW_W-1:0]              pad_h;

  // Input register
  logic                         s1_valid;
  logic [fbf_pkg::WORD_W-1:0]   s1_pixel;

  // Walk counters
  logic [CW-1:0]                col;
  logic [CW-1:0]                row;
  logic [CW-1:0]                col_next;
  logic [CW-1:0]                row_next;

  // Result register
  logic                         wr_valid;
  logic [fbf_pkg::IDX_W-1:0]    wr_index;
  logic [fbf_pkg::WORD_W-1:0]   wr_word;
  logic                         wr_last;

  logic                         out_free;
  logic                         s1_fire;
  logic                         last_col;
  logic                         last_row;
  logic [PROD_W-1:0]            row_base;
  logic [PROD_W:0]              index_full;
  logic [fbf_pkg::WORD_W-1:0]   word;

  fbf_cfg #(
    .TILE_PIXELS   (TILE_PIXELS),
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_cfg (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .regs  (regs),
    .buf_w (buf_w),
    .buf_h (buf_h),
    .pad_w (pad_w),
    .pad_h (pad_h)
  );

  fbf_pixel #(
    .TILE_PIXELS   (TILE_PIXELS),
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_pixel (
    .col          (col),
    .row          (row),
    .regs         (regs),
    .buf_w        (buf_w),
    .buf_h        (buf_h),
    .source_pixel (s1_pixel),
    .word         (word)
  );

  // Advance the input register whenever the result register frees up
  assign out_free     = !wr_valid || writes.ready;
  assign s1_fire      = s1_valid && out_free;
  assign pixels.ready = !s1_valid || out_free;

  // Compare against padded size minus one as counter plus one, so a stale
  // counter at or beyond the edge wraps
  assign last_col = (LIM_W'(col) + LIM_W'(1)) >= LIM_W'(pad_w);
  assign last_row = (LIM_W'(row) + LIM_W'(1)) >= LIM_W'(pad_h);

  assign row_base   = PROD_W'(row) * PROD_W'(pad_w);
  assign index_full = (PROD_W+1)'(row_base) + (PROD_W+1)'(col);

  always_comb begin
    if (last_col) begin
      col_next = '0;
      row_next = last_row ? '0 : CW'(row + CW'(1));
    end else begin
      col_next = CW'(col + CW'(1));
      row_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wr_valid <= 1'b0;
      col      <= '0;
      row      <= '0;
    end else begin
      if (pixels.ready) begin
        s1_valid <= pixels.valid;
      end
      if (out_free) begin
        wr_valid <= s1_valid;
      end
      if (s1_fire) begin
        col <= col_next;
        row <= row_next;
      end
    end
  end

  // Payload registers: hold unless the stage takes a new pixel
  always_ff @(posedge clk) begin
    if (pixels.valid && pixels.ready) begin
      s1_pixel <= pixels.source_pixel;
    end
    if (s1_fire) begin
      wr_index <= fbf_pkg::IDX_W'(index_full);
      wr_word  <= word;
      wr_last  <= last_col && last_row;
    end
  end

  assign writes.valid       = wr_valid;
  assign writes.pixel_index = wr_index;
  assign writes.pixel_word  = wr_word;
  assign writes.frame_last  = wr_last;

  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    s1_fire && last_col |=> col == '0)
    else $error("column counter did not wrap at the padded edge");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    s1_fire && last_col && last_row |=> (col == '0) && (row == '0))
    else $error("walk did not restart after the last pixel of the frame");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_pixel) && $stable(col))
    else $error("stalled pixel lost or walk advanced under stall");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> wr_valid)
    else $error("pixel left the input register without a result");

  a_pad_nonzero: assert property (@(posedge clk) disable iff (rst)
    (pad_w != '0) && (pad_h != '0))
    else $error("padded size is zero");

endmodule

### tb/sv/tb_tiled_frame_buffer_fill.sv
`timescale 1ns / 1ps
// Self-checking testbench for tiled_frame_buffer_fill: directed table, then random phases.
// Depends on fbf_pkg, the channel interfaces in fbf_if.sv and the block itself.
module tb_tiled_frame_buffer_fill;

  localparam int          TILE        = fbf_pkg::TILE_PIXELS_DEF;
  localparam logic [1:0]  FILL_UNUSED = 2'd3;  // mode code with no fill behind it

  // One pixel write as it leaves the block
  typedef struct packed {
    logic [fbf_pkg::IDX_W-1:0]  pixel_index;
    logic [fbf_pkg::WORD_W-1:0] pixel_word;
    logic                       frame_last;
  } pixel_write_t;

  typedef enum logic [1:0] {
    ROW_CONFIG,  // register write, taken while the block is idle
    ROW_PIXEL,   // pixel transfer, expectation from the walk predictor
    ROW_KNOWN    // pixel transfer with the expected write typed in
  } plan_kind_t;

  typedef struct packed {
    plan_kind_t          kind;
    fbf_pkg::cfg_reg_t   reg_sel;
    logic [31:0]         data;
    pixel_write_t        result;
  } plan_row_t;

  // Directed opening. Counters start at the origin after reset, so the index of
  // every typed row is simply the number of pixels sent before it on row zero.
  localparam plan_row_t PLAN [26] = '{
    // after reset: image mode with an empty image, so the word is cleared
    '{ROW_KNOWN,  fbf_pkg::REG_FILL_MODE,     32'hffffffff, '{22'd0,  32'h00000000, 1'b0}},
    '{ROW_CONFIG, fbf_pkg::REG_SRC_WIDTH,     32'h00000800, '0},
    '{ROW_CONFIG, fbf_pkg::REG_SRC_HEIGHT,    32'hfffff800, '0},
    // premultiply extremes: opaque white, zero alpha, half alpha, black
    '{ROW_KNOWN,  fbf_pkg::REG_FILL_MODE,     32'hffffffff, '{22'd1,  32'hffffffff, 1'b0}},
    '{ROW_KNOWN,  fbf_pkg::REG_FILL_MODE,     32'h00ffffff, '{22'd2,  32'h00000000, 1'b0}},
    '{ROW_KNOWN,  fbf_pkg::REG_FILL_MODE,     32'h80ffffff, '{22'd3,  32'h80808080, 1'b0}},
    '{ROW_KNOWN,  fbf_pkg::REG_FILL_MODE,     32'hff000000, '{22'd4,  32'hff000000, 1'b0}},
    '{ROW_PIXEL,  fbf_pkg::REG_FILL_MODE,     32'h7f3c9a21, '0},
    '{ROW_PIXEL,  fbf_pkg::REG_FILL_MODE,     32'h01fe0102, '0},
    '{ROW_PIXEL,  fbf_pkg::REG_FILL_MODE,     32'hc0804020, '0},
    '{ROW_CONFIG, fbf_pkg::REG_FILL_MODE,     32'(fbf_pkg::FILL_CHECKER), '0},
    // chequer: column square 1 against row square 0, plain white inside
    '{ROW_KNOWN,  fbf_pkg::REG_FILL_MODE,     32'h00000000, '{22'd8,  32'hffffffff, 1'b0}},
    '{ROW_PIXEL,  fbf_pkg::REG_FILL_MODE,     32'hffffffff, '0},
    // zero width saturates to one column, so the next pixel is outside
    '{ROW_CONFIG, fbf_pkg::REG_BUFFER_WIDTH,  32'h00000000, '0},
    '{ROW_KNOWN,  fbf_pkg::REG_FILL_MODE,     32'h12345678, '{22'd10, 32'h00000000, 1'b0}},
    // oversized width saturates to the maximum; padded width follows
    '{ROW_CONFIG, fbf_pkg::REG_BUFFER_WIDTH,  32'h00000fff, '0},
    '{ROW_CONFIG, fbf_pkg::REG_FILL_MODE,     32'(fbf_pkg::FILL_SOLID), '0},
    '{ROW_CONFIG, fbf_pkg::REG_SOLID_COLOR,   32'hffffffff, '0},
    '{ROW_KNOWN,  fbf_pkg::REG_FILL_MODE,     32'h00000000, '{22'd11, 32'hffffffff, 1'b0}},
    '{ROW_CONFIG, fbf_pkg::REG_BUFFER_HEIGHT, 32'h00000000, '0},
    '{ROW_CONFIG, fbf_pkg::REG_SOLID_COLOR,   32'h12345678, '0},
    '{ROW_KNOWN,  fbf_pkg::REG_FILL_MODE,     32'hdeadbeef, '{22'd12, 32'h12345678, 1'b0}},
    // unused mode writes transparent black
    '{ROW_CONFIG, fbf_pkg::REG_FILL_MODE,     32'(FILL_UNUSED), '0},
    '{ROW_KNOWN,  fbf_pkg::REG_FILL_MODE,     32'hffffffff, '{22'd13, 32'h00000000, 1'b0}},
    '{ROW_CONFIG, fbf_pkg::REG_BUFFER_HEIGHT, 32'h00001fff, '0},
    '{ROW_KNOWN,  fbf_pkg::REG_FILL_MODE,     32'h5a5aa5a5, '{22'd14, 32'h00000000, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  fbf_cfg_if   cfg ();
  fbf_pixel_if pixels ();
  fbf_write_if writes ();

  tiled_frame_buffer_fill u_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .pixels (pixels),
    .writes (writes)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor copy of the registers and the raster walk
  logic [1:0]   fill_sel;
  logic [11:0]  buf_w;
  logic [11:0]  buf_h;
  logic [11:0]  img_w;
  logic [11:0]  img_h;
  logic [31:0]  solid_rgba;
  int unsigned  walk_col;
  int unsigned  walk_row;

  pixel_write_t pending_writes[$];  // writes still owed by the block, oldest first
  int           errors;
  bit           steady;             // when set, both sides run without gaps

  // Saturate a buffer dimension into 1..MAX_DIMENSION
  function automatic int unsigned fit_size(input logic [11:0] v);
    if (v == 0) return 1;
    if (v > fbf_pkg::MAX_DIMENSION_DEF) return fbf_pkg::MAX_DIMENSION_DEF;
    return v;
  endfunction

  function automatic int unsigned tile_round(input int unsigned v);
    return ((v + TILE - 1) / TILE) * TILE;
  endfunction

  // Work out the write for one source pixel and advance the walk
  function automatic pixel_write_t next_write(input logic [31:0] src);
    int unsigned  bw;
    int unsigned  bh;
    int unsigned  pw;
    int unsigned  ph;
    int unsigned  alpha;
    int unsigned  chan;
    bit           in_buf;
    bit           end_col;
    bit           end_row;
    pixel_write_t w;
    bw = fit_size(buf_w);
    bh = fit_size(buf_h);
    pw = tile_round(bw);
    ph = tile_round(bh);
    in_buf = (walk_col < bw) && (walk_row < bh);
    w.pixel_word = '0;
    case (fill_sel)
      fbf_pkg::FILL_IMAGE: begin
        if (walk_col < img_w && walk_row < img_h) begin
          alpha = src[31:24];
          w.pixel_word[31:24] = src[31:24];
          for (int k = 0; k < 3; k++) begin
            chan = src[8*k +: 8];
            w.pixel_word[8*k +: 8] = 8'((chan * alpha) / 255);
          end
        end
      end
      fbf_pkg::FILL_CHECKER: begin
        w.pixel_word = in_buf ? '1 : '0;
        // grey squares where column and row squares share parity, padding too
        if (walk_col[fbf_pkg::CHECK_BIT] == walk_row[fbf_pkg::CHECK_BIT])
          w.pixel_word[23:0] = {3{fbf_pkg::CHECK_GREY}};
      end
      fbf_pkg::FILL_SOLID: begin
        if (in_buf) w.pixel_word = solid_rgba;
      end
      default: ;
    endcase
    // a column left beyond a shrunken frame wraps on this pixel, a row at row end
    end_col = walk_col >= pw - 1;
    end_row = walk_row >= ph - 1;
    w.pixel_index = fbf_pkg::IDX_W'(walk_row * pw + walk_col);
    w.frame_last  = end_col && end_row;
    if (end_col) begin
      walk_col = 0;
      walk_row = end_row ? 0 : walk_row + 1;
    end else begin
      walk_col = walk_col + 1;
    end
    return w;
  endfunction

  // Random noise above the register's width, which the block must drop
  function automatic logic [31:0] noisy(input logic [31:0] field, input int width);
    logic [31:0] keep;
    keep = (32'd1 << width) - 1;
    return (field & keep) | (($urandom_range(0, 3) == 0) ? ($urandom & ~keep) : 32'd0);
  endfunction

  function automatic logic [31:0] random_pixel();
    logic [31:0] p;
    p = $urandom;
    case ($urandom_range(0, 3))
      0: p[31:24] = 8'h00;
      1: p[31:24] = 8'hff;
      default: ;
    endcase
    return p;
  endfunction

  // Drop pixel valid and hold until every owed write has come back
  task automatic settle();
    pixels.valid = 1'b0;
    while (pending_writes.size() != 0) @(negedge clk);
  endtask

  // One register transfer; the predictor copy follows at the accepting edge
  task automatic write_reg(input fbf_pkg::cfg_reg_t sel, input logic [31:0] value);
    cfg.index = sel;
    cfg.value = value;
    cfg.valid = 1'b1;
    do @(posedge clk); while (!cfg.ready);
    case (sel)
      fbf_pkg::REG_FILL_MODE:     fill_sel   = value[1:0];
      fbf_pkg::REG_BUFFER_WIDTH:  buf_w      = value[11:0];
      fbf_pkg::REG_BUFFER_HEIGHT: buf_h      = value[11:0];
      fbf_pkg::REG_SRC_WIDTH:     img_w      = value[11:0];
      fbf_pkg::REG_SRC_HEIGHT:    img_h      = value[11:0];
      fbf_pkg::REG_SOLID_COLOR:   solid_rgba = value;
      default: ;
    endcase
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  // One pixel transfer after a random gap. Valid stays high on return, so a
  // following transfer with no gap keeps it high without a glitch.
  task automatic push_pixel(input logic [31:0] px, input bit use_given,
                            input pixel_write_t given, output pixel_write_t got);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      pixels.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixels.source_pixel = px;
    pixels.valid        = 1'b1;
    do @(posedge clk); while (!pixels.ready);
    got = next_write(px);
    pending_writes.push_back(use_given ? given : got);
    @(negedge clk);
  endtask

  // Rewrite every register for a new phase; wild lets sizes reach the extremes
  task automatic setup_phase(input int unsigned w_max, input int unsigned h_min,
                             input int unsigned h_max, input bit wild);
    logic [11:0] w;
    logic [11:0] h;
    settle();
    steady = ($urandom_range(0, 3) == 0);
    write_reg(fbf_pkg::REG_FILL_MODE, noisy(32'($urandom_range(0, 3)), 2));
    w = (wild && $urandom_range(0, 5) == 0) ? 12'($urandom) : 12'($urandom_range(1, w_max));
    h = (wild && $urandom_range(0, 5) == 0) ? 12'($urandom) : 12'($urandom_range(h_min, h_max));
    write_reg(fbf_pkg::REG_BUFFER_WIDTH, noisy(32'(w), fbf_pkg::REG_W));
    write_reg(fbf_pkg::REG_BUFFER_HEIGHT, noisy(32'(h), fbf_pkg::REG_W));
    write_reg(fbf_pkg::REG_SRC_WIDTH, noisy((wild && $urandom_range(0, 5) == 0) ?
        $urandom_range(0, 4095) : $urandom_range(0, fit_size(w) + 8), fbf_pkg::REG_W));
    write_reg(fbf_pkg::REG_SRC_HEIGHT, noisy((wild && $urandom_range(0, 5) == 0) ?
        $urandom_range(0, 4095) : $urandom_range(0, fit_size(h) + 8), fbf_pkg::REG_W));
    write_reg(fbf_pkg::REG_SOLID_COLOR, $urandom);
  endtask

  // Short phase of random pixels under freshly drawn settings
  task automatic short_phase();
    pixel_write_t got;
    setup_phase(40, 1, 40, 1'b1);
    repeat ($urandom_range(16, 60)) push_pixel(random_pixel(), 1'b0, '0, got);
  endtask

  // Compare every accepted write with the oldest expectation
  always @(posedge clk) begin : check_writes
    pixel_write_t want;
    if (!rst && writes.valid && writes.ready) begin
      if (pending_writes.size() == 0) begin
        $error("pixel write with nothing expected: index %0d word %h",
               writes.pixel_index, writes.pixel_word);
        errors++;
      end else begin
        want = pending_writes.pop_front();
        if (writes.pixel_index !== want.pixel_index) begin
          $error("pixel_index: expected %0d, got %0d", want.pixel_index, writes.pixel_index);
          errors++;
        end
        if (writes.pixel_word !== want.pixel_word) begin
          $error("pixel_word: expected %h, got %h", want.pixel_word, writes.pixel_word);
          errors++;
        end
        if (writes.frame_last !== want.frame_last) begin
          $error("frame_last: expected %b, got %b", want.frame_last, writes.frame_last);
          errors++;
        end
      end
    end
  end

  // Receiver: stall a random number of cycles before each transfer
  initial begin : write_sink
    int stall;
    writes.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        writes.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      writes.ready = 1'b1;
      do @(posedge clk); while (!writes.valid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    pixel_write_t got;
    pixels.valid        = 1'b0;
    pixels.source_pixel = '0;
    cfg.valid           = 1'b0;
    cfg.index           = fbf_pkg::REG_FILL_MODE;
    cfg.value           = '0;
    errors              = 0;
    steady              = 1'b0;
    fill_sel            = fbf_pkg::FILL_IMAGE;
    buf_w               = 12'(fbf_pkg::BUFFER_RESET);
    buf_h               = 12'(fbf_pkg::BUFFER_RESET);
    img_w               = '0;
    img_h               = '0;
    solid_rgba          = '0;
    walk_col            = 0;
    walk_row            = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Walk the directed table
    foreach (PLAN[i]) begin
      case (PLAN[i].kind)
        ROW_CONFIG: begin
          settle();
          write_reg(PLAN[i].reg_sel, PLAN[i].data);
        end
        ROW_PIXEL: push_pixel(PLAN[i].data, 1'b0, '0, got);
        default:   push_pixel(PLAN[i].data, 1'b1, PLAN[i].result, got);
      endcase
    end

    // Random phases; shrinking sizes leave the counters beyond the frame
    repeat (6) short_phase();
    repeat (6) short_phase();

    settle();
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("tiled_frame_buffer_fill regression: pass");
    end else begin
      $display("tiled_frame_buffer_fill regression: fail");
    end
    $finish;
  end

  // Watchdog, several times the slowest correct run
  initial begin : watchdog
    #5ms;
    $display("tiled_frame_buffer_fill regression: fail");
    $finish;
  end

endmodule
